FILE: hw/rtl/hbs_pkg.sv
// ----------------------------------------------------------------------------
// hbs_pkg: shared types and constants for the heater burner sequencer
// Register indexes, mode and status codes, timing and temperature limits,
// and the structs passed between the top level and the evaluation logic.
// ----------------------------------------------------------------------------
package hbs_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_MODE           = 3'd0;
   localparam logic [2:0] CSR_HIGH_SETPOINT  = 3'd1;
   localparam logic [2:0] CSR_LOW_SETPOINT   = 3'd2;
   localparam logic [2:0] CSR_GAS_RUN_MS     = 3'd3;
   localparam logic [2:0] CSR_GAS_REST_MS    = 3'd4;
   localparam logic [2:0] CSR_EXHAUST_TRIP   = 3'd5;
   localparam logic [2:0] CSR_EXHAUST_RESUME = 3'd6;
   localparam logic [2:0] CSR_ROOM_TRIP      = 3'd7;

   typedef enum logic [2:0] {
      MODE_UNOCC   = 3'd1,
      MODE_OCC     = 3'd2,
      MODE_OFF     = 3'd3,
      MODE_EXHAUST = 3'd4,
      MODE_FAN     = 3'd5
   } mode_type;

   typedef enum logic [3:0] {
      ST_OFF      = 4'd0,
      ST_SAFETY   = 4'd1,
      ST_STARTING = 4'd2,
      ST_HEATING  = 4'd3,
      ST_REST     = 4'd4,
      ST_THERMAL  = 4'd5,
      ST_HOLDING  = 4'd6,
      ST_COOLDOWN = 4'd7,
      ST_MANUAL   = 4'd8
   } status_type;

   localparam logic [31:0]        FAN_DELAY_MS      = 32'd1000;
   localparam logic [31:0]        FAN_EXTEND_MS     = 32'd30000;
   localparam logic signed [14:0] HYSTERESIS_TENTHS = 15'sd10;
   localparam logic signed [14:0] COOL_ROOM_LIMIT   = 15'sd1500;
   localparam logic signed [14:0] COOL_VENT_LIMIT   = 15'sd2000;
   localparam logic [9:0]         SETPOINT_MIN      = 10'd320;
   localparam logic [9:0]         SETPOINT_MAX      = 10'd990;

   // reset values of the configuration registers
   localparam logic [2:0]         MODE_RESET           = 3'd3;
   localparam logic [9:0]         HIGH_SETPOINT_RESET  = 10'd660;
   localparam logic [9:0]         LOW_SETPOINT_RESET   = 10'd380;
   localparam logic [31:0]        GAS_RUN_MS_RESET     = 32'd300000;
   localparam logic [31:0]        GAS_REST_MS_RESET    = 32'd90000;
   localparam logic signed [14:0] EXHAUST_TRIP_RESET   = 15'sd1500;
   localparam logic signed [14:0] EXHAUST_RESUME_RESET = 15'sd1200;
   localparam logic signed [14:0] ROOM_TRIP_RESET      = 15'sd1200;

   typedef struct packed {
      logic [2:0]  mode;
      logic [9:0]  high_setpoint;
      logic [9:0]  low_setpoint;
      logic [31:0] gas_run_ms;
      logic [31:0] gas_rest_ms;
      logic [14:0] exhaust_trip;
      logic [14:0] exhaust_resume;
      logic [14:0] room_trip;
   } hbs_cfg_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [14:0] room_temp;
      logic [14:0] vent_temp;
      logic [14:0] board_temp;
      logic        sens_ok;
      logic        fan_failure;
   } hbs_item_type;

   typedef struct packed {
      logic        started;
      logic [31:0] gas_start_time;
      logic [31:0] rest_start_time;
      logic [31:0] stop_time;
      logic        thermal_latch;
      logic        gas_drive;
      logic        fan_drive;
      logic        exhaust_drive;
   } hbs_state_type;

   typedef struct packed {
      logic       gas_on;
      logic       fan_on;
      logic       exh_on;
      status_type status;
   } hbs_result_type;

   // wrapping "now is past base + d"
   function automatic logic later_than(input logic [31:0] now,
                                       input logic [31:0] base,
                                       input logic [31:0] d);
      logic [31:0] lim;
      lim = base + d;
      return now > lim;
   endfunction

endpackage

FILE: hw/rtl/heater_burner_sequencer.sv
// ----------------------------------------------------------------------------
// heater_burner_sequencer: gas heater burner control sequencer
// Evaluates one sensor word per handshake and returns the relay drives.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one evaluation word: time stamp, three temperatures, the
//   fan failure flag in tdata and the sensors-valid flag in tuser.
//   rsp_* returns one word per evaluation: gas, fan and exhaust drives and
//   a status code.
//   csr_* writes the eight control registers; write it only while idle.
// Timing:
//   A word taken on req_ is registered in the input register, evaluated
//   combinationally and placed in the response register, where its result
//   is held valid until taken. One word per cycle is sustained while
//   rsp_tready stays high; the step is a single pass of compare and add logic
//   between the input and output registers.
// Reset:
//   Sets the registers to their defaults (mode full off) and clears all
//   burner state and the valid flags of both pipeline registers.
// Stall:
//   While rsp_tready is low the response holds; one more word can wait in
//   the input register, after which req_tready drops.
// ----------------------------------------------------------------------------
module heater_burner_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // now_ms[31:0], room_temp[46:32], vent_temp[61:47], board_temp[76:62],
   // fan_failure[77], zero[79:78]
   input  logic [79:0] req_tdata,
   // sens_ok[0]
   input  logic [0:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // gas_on[0], fan_on[1], exh_on[2], status[6:3], zero[7]
   output logic [7:0]  rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import hbs_pkg::*;

   hbs_cfg_type    cfg_ff;
   hbs_cfg_type    cfg_in;
   logic           in_valid_ff;
   logic           in_valid_in;
   hbs_item_type   in_item_ff;
   hbs_item_type   in_item;
   hbs_state_type  state_ff;
   hbs_state_type  state_in;
   logic           out_valid_ff;
   logic           out_valid_in;
   hbs_result_type out_res_ff;
   hbs_result_type res;
   logic           out_free;
   logic           advance;
   logic           req_take;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign in_item.now_ms      = req_tdata[31:0];
   assign in_item.room_temp   = req_tdata[46:32];
   assign in_item.vent_temp   = req_tdata[61:47];
   assign in_item.board_temp  = req_tdata[76:62];
   assign in_item.fan_failure = req_tdata[77];
   assign in_item.sens_ok     = req_tuser[0];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:           cfg_in.mode           = csr_data[2:0];
            CSR_HIGH_SETPOINT:  cfg_in.high_setpoint  = csr_data[9:0];
            CSR_LOW_SETPOINT:   cfg_in.low_setpoint   = csr_data[9:0];
            CSR_GAS_RUN_MS:     cfg_in.gas_run_ms     = csr_data;
            CSR_GAS_REST_MS:    cfg_in.gas_rest_ms    = csr_data;
            CSR_EXHAUST_TRIP:   cfg_in.exhaust_trip   = csr_data[14:0];
            CSR_EXHAUST_RESUME: cfg_in.exhaust_resume = csr_data[14:0];
            CSR_ROOM_TRIP:      cfg_in.room_trip      = csr_data[14:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   hbs_state_type next_st;

   hbs_eval u_eval (
      .cfg_i    (cfg_ff),
      .item_i   (in_item_ff),
      .state_i  (state_ff),
      .state_o  (next_st),
      .result_o (res)
   );

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
      state_in     = advance ? next_st : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode           <= MODE_RESET;
         cfg_ff.high_setpoint  <= HIGH_SETPOINT_RESET;
         cfg_ff.low_setpoint   <= LOW_SETPOINT_RESET;
         cfg_ff.gas_run_ms     <= GAS_RUN_MS_RESET;
         cfg_ff.gas_rest_ms    <= GAS_REST_MS_RESET;
         cfg_ff.exhaust_trip   <= EXHAUST_TRIP_RESET;
         cfg_ff.exhaust_resume <= EXHAUST_RESUME_RESET;
         cfg_ff.room_trip      <= ROOM_TRIP_RESET;
         state_ff              <= '0;
         in_valid_ff           <= 1'b0;
         out_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= in_item;
      end
      if (advance) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_res_ff.status, out_res_ff.exh_on,
                        out_res_ff.fan_on, out_res_ff.gas_on};

endmodule

FILE: hw/rtl/hbs_eval.sv
// ----------------------------------------------------------------------------
// hbs_eval: one evaluation step of the burner sequencer
// Pure combinational next state and result for one registered input word.
// ----------------------------------------------------------------------------
module hbs_eval (
   input  hbs_pkg::hbs_cfg_type    cfg_i,
   input  hbs_pkg::hbs_item_type   item_i,
   input  hbs_pkg::hbs_state_type  state_i,
   output hbs_pkg::hbs_state_type  state_o,
   output hbs_pkg::hbs_result_type result_o
);
   import hbs_pkg::*;

   logic signed [14:0] room;
   logic signed [14:0] vent;
   logic signed [14:0] board;
   logic [31:0]        now;
   mode_type           eff_mode;
   logic [9:0]         sp_raw;
   logic [9:0]         sp;
   logic signed [14:0] sp_lo;
   logic signed [14:0] sp_hi;

   hbs_state_type stop_st;
   status_type    stop_status;
   hbs_state_type run_st;
   status_type    run_status;
   logic          resume;
   hbs_state_type safe_st;
   logic          trip_any;

   hbs_state_type st;
   status_type    status;

   assign room  = $signed(item_i.room_temp);
   assign vent  = $signed(item_i.vent_temp);
   assign board = $signed(item_i.board_temp);
   assign now   = item_i.now_ms;

   // out-of-range modes: zero acts as unoccupied, six and seven as forced fan
   always_comb begin
      if (cfg_i.mode < MODE_UNOCC) begin
         eff_mode = MODE_UNOCC;
      end else if (cfg_i.mode > MODE_FAN) begin
         eff_mode = MODE_FAN;
      end else begin
         eff_mode = mode_type'(cfg_i.mode);
      end
   end

   always_comb begin
      sp_raw = (eff_mode == MODE_OCC) ? cfg_i.high_setpoint : cfg_i.low_setpoint;
      if (sp_raw < SETPOINT_MIN) begin
         sp = SETPOINT_MIN;
      end else if (sp_raw > SETPOINT_MAX) begin
         sp = SETPOINT_MAX;
      end else begin
         sp = sp_raw;
      end
      sp_lo = $signed({5'b0, sp});
      sp_hi = sp_lo + HYSTERESIS_TENTHS;
   end

   // stop sequence, shared by fan failure and the warm-room release
   always_comb begin
      stop_st = state_i;
      if (stop_st.started) begin
         stop_st.gas_drive = 1'b0;
         stop_st.started   = 1'b0;
         stop_st.stop_time = now;
      end
      if (later_than(now, stop_st.stop_time, FAN_EXTEND_MS)) begin
         if (room < COOL_ROOM_LIMIT && vent < COOL_VENT_LIMIT) begin
            stop_st.exhaust_drive = 1'b0;
         end
         stop_st.fan_drive = 1'b0;
         stop_st.gas_drive = 1'b0;
         stop_status = stop_st.exhaust_drive ? ST_COOLDOWN : ST_OFF;
      end else begin
         stop_status = ST_COOLDOWN;
      end
   end

   // run sequence: start, fan delay, burn limit, rest or thermal wait
   always_comb begin
      run_st = state_i;
      resume = 1'b0;
      if (!run_st.started) begin
         run_st.started        = 1'b1;
         run_st.gas_drive      = 1'b1;
         run_st.exhaust_drive  = 1'b1;
         run_st.gas_start_time = now;
      end
      if (later_than(now, run_st.gas_start_time, FAN_DELAY_MS)) begin
         run_st.fan_drive     = 1'b1;
         run_st.exhaust_drive = 1'b1;
      end
      if (run_st.fan_drive && run_st.gas_drive &&
          later_than(now, run_st.gas_start_time, cfg_i.gas_run_ms)) begin
         run_st.gas_drive       = 1'b0;
         run_st.rest_start_time = now;
      end
      if (run_st.fan_drive && !run_st.gas_drive) begin
         if (run_st.thermal_latch) begin
            resume = vent < $signed(cfg_i.exhaust_resume);
            if (resume) begin
               run_st.thermal_latch   = 1'b0;
               run_st.rest_start_time = now - cfg_i.gas_rest_ms;
            end
         end else begin
            resume = later_than(now, run_st.rest_start_time, cfg_i.gas_rest_ms);
         end
         if (resume) begin
            run_st.gas_start_time = now;
            run_st.gas_drive      = 1'b1;
         end
      end
      if (!run_st.fan_drive) begin
         run_status = ST_STARTING;
      end else if (run_st.gas_drive) begin
         run_status = ST_HEATING;
      end else begin
         run_status = run_st.thermal_latch ? ST_THERMAL : ST_REST;
      end
   end

   // over-temperature cut; the latch is set before the rest timer is touched
   always_comb begin
      safe_st = state_i;
      trip_any = 1'b0;
      if (vent > $signed(cfg_i.exhaust_trip)) begin
         safe_st.thermal_latch = 1'b1;
         trip_any = 1'b1;
      end
      if (board > $signed(cfg_i.room_trip) || room > $signed(cfg_i.room_trip)) begin
         trip_any = 1'b1;
      end
      if (trip_any) begin
         safe_st.gas_drive = 1'b0;
         if (!safe_st.thermal_latch) begin
            safe_st.rest_start_time = now;
         end
      end
   end

   always_comb begin
      st = state_i;
      status = ST_OFF;
      unique case (eff_mode)
         MODE_OFF: begin
            st.exhaust_drive = 1'b0;
            st.fan_drive     = 1'b0;
            st.gas_drive     = 1'b0;
            st.started       = 1'b0;
            status           = ST_OFF;
         end
         MODE_EXHAUST: begin
            st.exhaust_drive = 1'b1;
            st.fan_drive     = 1'b0;
            st.gas_drive     = 1'b0;
            status           = ST_MANUAL;
         end
         MODE_FAN: begin
            st.exhaust_drive = 1'b1;
            st.fan_drive     = 1'b1;
            st.gas_drive     = 1'b0;
            status           = ST_MANUAL;
         end
         default: begin
            if (!item_i.sens_ok) begin
               st.gas_drive = 1'b0;
               if (!st.thermal_latch) begin
                  st.rest_start_time = now;
               end
               status = ST_SAFETY;
            end else if (item_i.fan_failure) begin
               st     = stop_st;
               status = ST_SAFETY;
            end else if (trip_any) begin
               st     = safe_st;
               status = ST_SAFETY;
            end else if (room < sp_lo) begin
               st     = run_st;
               status = run_status;
            end else if (room > sp_hi) begin
               st     = stop_st;
               status = stop_status;
            end else begin
               status = ST_HOLDING;
            end
         end
      endcase
   end

   assign state_o         = st;
   assign result_o.gas_on = st.gas_drive;
   assign result_o.fan_on = st.fan_drive;
   assign result_o.exh_on = st.exhaust_drive;
   assign result_o.status = status;

endmodule
